[src/assert_macros.svh]
// Assertion macros for the port-level checker of the quaternion unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off during reset.
`define QRM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qrm: property violated");

// Antecedent implies consequent in the next cycle.
`define QRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrm: property violated");

`endif

[src/qrm_pkg.sv]
// Package for the quaternion rotate / multiply unit: widths, operation codes,
// and the stage records passed between pipeline modules. No dependencies.
`default_nettype none

package qrm_pkg;

    localparam int FRAC_BITS     = 15;
    localparam int VEC_WIDTH_DEF = 24;

    localparam int QW   = 18;              // quaternion input component
    localparam int OW   = 24;              // second operand x/y/z
    localparam int RWW  = FRAC_BITS + 3;   // result scalar
    localparam int PW   = QW + OW;         // qa * operand product
    localparam int SW   = 2 * QW;          // qa * scalar product
    localparam int CW   = PW + 1;          // cross product term
    localparam int DW   = PW + 2;          // dot product, Hamilton sums
    localparam int KW   = SW + 1;          // 2w^2 - 1
    localparam int SUMW = 64;              // rotation accumulator

    // split points for the second-level multiplies
    localparam int KL = 18;
    localparam int CL = 22;
    localparam int DL = 22;

    localparam int BKH_W = OW + KW - KL;
    localparam int BKL_W = OW + KL + 1;
    localparam int WCH_W = QW + CW - CL;
    localparam int WCL_W = QW + CL + 1;
    localparam int QDH_W = QW + DW - DL;
    localparam int QDL_W = QW + DL + 1;

    typedef logic [1:0] func_t;

    localparam func_t FUNC_ROT  = 2'd0;
    localparam func_t FUNC_IROT = 2'd1;
    localparam func_t FUNC_HAM  = 2'd2;
    localparam func_t FUNC_CONJ = 2'd3;

    typedef logic signed [QW-1:0] q_t;
    typedef logic signed [OW-1:0] o_t;
    typedef logic signed [PW-1:0] p_t;
    typedef logic signed [SW-1:0] sq_t;

    typedef struct packed {
        func_t func;
        q_t    x;
        q_t    y;
        q_t    z;
        q_t    w;
        o_t    bx;
        o_t    by;
        o_t    bz;
        q_t    bw;
    } in_t;

    typedef struct packed {
        func_t func;
        q_t    x;
        q_t    y;
        q_t    z;
        q_t    w;
        o_t    bx;
        o_t    by;
        o_t    bz;
        p_t    xbx;
        p_t    xby;
        p_t    xbz;
        p_t    ybx;
        p_t    yby;
        p_t    ybz;
        p_t    zbx;
        p_t    zby;
        p_t    zbz;
        p_t    wbx;
        p_t    wby;
        p_t    wbz;
        sq_t   xbw;
        sq_t   ybw;
        sq_t   zbw;
        sq_t   wbw;
        sq_t   ww;
    } s1_t;

    // index 0..3 = x, y, z, w
    typedef struct packed {
        func_t                func;
        logic [3:0][QW-1:0]   q;
        logic [2:0][OW-1:0]   bv;
        logic [2:0][CW-1:0]   c;
        logic [DW-1:0]        dot;
        logic [KW-1:0]        k;
        logic [3:0][DW-1:0]   h;
    } s2_t;

    typedef struct packed {
        func_t                 func;
        logic [3:0][QW-1:0]    q;
        logic [3:0][DW-1:0]    h;
        logic [2:0][BKH_W-1:0] bkh;
        logic [2:0][BKL_W-1:0] bkl;
        logic [2:0][WCH_W-1:0] wch;
        logic [2:0][WCL_W-1:0] wcl;
        logic [2:0][QDH_W-1:0] qdh;
        logic [2:0][QDL_W-1:0] qdl;
    } s3_t;

    typedef struct packed {
        func_t                func;
        logic [3:0][QW-1:0]   q;
        logic [3:0][DW-1:0]   h;
        logic [2:0][SUMW-1:0] tbk;
        logic [2:0][SUMW-1:0] twc;
        logic [2:0][SUMW-1:0] tqd;
    } s4_t;

endpackage

`default_nettype wire

[src/quaternion_rotate_multiply_unit_core.sv]
// Quaternion rotate / multiply unit, top level.
// Built from qrm_prod, qrm_comb, qrm_scale and qrm_out; uses qrm_pkg.
//
// Usage:
//   Input channel in_valid / in_stall carries one item: func, quaternion
//   qa (Q2.15) and the operand (vector Q8.15 or second quaternion).
//   func: rotate, inverse rotate, Hamilton product, conjugate.
//   Output channel out_valid / out_stall returns one result item per input:
//   res_x/y/z/w saturated, overflow set when any component clamped.
//   Throughput: one item per cycle, sustained while no finished result
//   is held by out_stall.
//   Stages: products, sums, split wide multiplies, recombine, round and
//   select, saturate into the output register.
//   Stall: the pipeline moves as one; when out_valid is high and out_stall
//   is asserted, every stage holds and in_stall rises in the same cycle.
//   Nothing is dropped or repeated.
//   Reset (rst_n low, async): all valid bits clear; data registers are not reset.
`default_nettype none

module quaternion_rotate_multiply_unit_core
    import qrm_pkg::*;
#(
    parameter int VEC_WIDTH = VEC_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             func,
    input  wire logic signed [QW-1:0]   qa_x,
    input  wire logic signed [QW-1:0]   qa_y,
    input  wire logic signed [QW-1:0]   qa_z,
    input  wire logic signed [QW-1:0]   qa_w,
    input  wire logic signed [OW-1:0]   opnd_x,
    input  wire logic signed [OW-1:0]   opnd_y,
    input  wire logic signed [OW-1:0]   opnd_z,
    input  wire logic signed [QW-1:0]   opnd_w,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [VEC_WIDTH-1:0] res_x,
    output logic signed [VEC_WIDTH-1:0] res_y,
    output logic signed [VEC_WIDTH-1:0] res_z,
    output logic signed [RWW-1:0]       res_w,
    output logic                        overflow
);

    logic en;
    in_t  din;
    logic v1, v2, v4;
    s1_t  s1;
    s2_t  s2;
    s4_t  s4;

    // one enable for every stage: hold only when a finished result waits
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        din      = '0;
        din.func = func;
        din.x    = qa_x;
        din.y    = qa_y;
        din.z    = qa_z;
        din.w    = qa_w;
        din.bx   = opnd_x;
        din.by   = opnd_y;
        din.bz   = opnd_z;
        din.bw   = opnd_w;
    end

    qrm_prod u_prod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (in_valid),
        .din     (din),
        .vld_reg (v1),
        .s1_reg  (s1)
    );

    qrm_comb u_comb
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (v1),
        .s1      (s1),
        .vld_reg (v2),
        .s2_reg  (s2)
    );

    qrm_scale u_scale
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (v2),
        .s2      (s2),
        .vld_reg (v4),
        .s4_reg  (s4)
    );

    qrm_out #(
        .VEC_WIDTH (VEC_WIDTH)
    ) u_out
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (v4),
        .s4      (s4),
        .out_vld (out_valid),
        .res_x   (res_x),
        .res_y   (res_y),
        .res_z   (res_z),
        .res_w   (res_w),
        .ovf     (overflow)
    );

endmodule

`default_nettype wire

[src/qrm_prod.sv]
// Stage 1 of the quaternion unit: all first-level component products.
// Depends on qrm_pkg.
`default_nettype none

module qrm_prod
    import qrm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_vld,
    input  wire in_t  din,
    output logic      vld_reg,
    output s1_t       s1_reg
);

    s1_t s1_next;

    always_comb
    begin
        s1_next      = '0;
        s1_next.func = din.func;
        s1_next.x    = din.x;
        s1_next.y    = din.y;
        s1_next.z    = din.z;
        s1_next.w    = din.w;
        s1_next.bx   = din.bx;
        s1_next.by   = din.by;
        s1_next.bz   = din.bz;
        s1_next.xbx  = $signed(din.x) * $signed(din.bx);
        s1_next.xby  = $signed(din.x) * $signed(din.by);
        s1_next.xbz  = $signed(din.x) * $signed(din.bz);
        s1_next.ybx  = $signed(din.y) * $signed(din.bx);
        s1_next.yby  = $signed(din.y) * $signed(din.by);
        s1_next.ybz  = $signed(din.y) * $signed(din.bz);
        s1_next.zbx  = $signed(din.z) * $signed(din.bx);
        s1_next.zby  = $signed(din.z) * $signed(din.by);
        s1_next.zbz  = $signed(din.z) * $signed(din.bz);
        s1_next.wbx  = $signed(din.w) * $signed(din.bx);
        s1_next.wby  = $signed(din.w) * $signed(din.by);
        s1_next.wbz  = $signed(din.w) * $signed(din.bz);
        s1_next.xbw  = $signed(din.x) * $signed(din.bw);
        s1_next.ybw  = $signed(din.y) * $signed(din.bw);
        s1_next.zbw  = $signed(din.z) * $signed(din.bw);
        s1_next.wbw  = $signed(din.w) * $signed(din.bw);
        s1_next.ww   = $signed(din.w) * $signed(din.w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s1_reg <= s1_next;
    end

endmodule

`default_nettype wire

[src/qrm_comb.sv]
// Stage 2 of the quaternion unit: cross, dot, 2w^2-1 and Hamilton sums.
// Depends on qrm_pkg.
`default_nettype none

module qrm_comb
    import qrm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_vld,
    input  wire s1_t  s1,
    output logic      vld_reg,
    output s2_t       s2_reg
);

    localparam logic signed [KW-1:0] K_ONE = KW'(1) << (2 * FRAC_BITS);

    s2_t s2_next;

    always_comb
    begin
        s2_next      = '0;
        s2_next.func = s1.func;
        s2_next.q[0] = s1.x;
        s2_next.q[1] = s1.y;
        s2_next.q[2] = s1.z;
        s2_next.q[3] = s1.w;
        s2_next.bv[0] = s1.bx;
        s2_next.bv[1] = s1.by;
        s2_next.bv[2] = s1.bz;

        // inverse rotation flips the cross term
        if (s1.func == FUNC_IROT)
        begin
            s2_next.c[0] = CW'($signed(s1.zby) - $signed(s1.ybz));
            s2_next.c[1] = CW'($signed(s1.xbz) - $signed(s1.zbx));
            s2_next.c[2] = CW'($signed(s1.ybx) - $signed(s1.xby));
        end
        else
        begin
            s2_next.c[0] = CW'($signed(s1.ybz) - $signed(s1.zby));
            s2_next.c[1] = CW'($signed(s1.zbx) - $signed(s1.xbz));
            s2_next.c[2] = CW'($signed(s1.xby) - $signed(s1.ybx));
        end

        s2_next.dot = DW'($signed(s1.xbx)) + DW'($signed(s1.yby)) + DW'($signed(s1.zbz));
        s2_next.k   = $signed({s1.ww, 1'b0}) - K_ONE;

        s2_next.h[0] = DW'($signed(s1.xbw)) + DW'($signed(s1.ybz))
                     - DW'($signed(s1.zby)) + DW'($signed(s1.wbx));
        s2_next.h[1] = DW'($signed(s1.ybw)) - DW'($signed(s1.xbz))
                     + DW'($signed(s1.zbx)) + DW'($signed(s1.wby));
        s2_next.h[2] = DW'($signed(s1.xby)) - DW'($signed(s1.ybx))
                     + DW'($signed(s1.zbw)) + DW'($signed(s1.wbz));
        s2_next.h[3] = DW'($signed(s1.wbw)) - DW'($signed(s1.xbx))
                     - DW'($signed(s1.yby)) - DW'($signed(s1.zbz));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s2_reg <= s2_next;
    end

endmodule

`default_nettype wire

[src/qrm_scale.sv]
// Stages 3 and 4 of the quaternion unit: wide second-level multiplies split
// into two partial products, then recombined. Depends on qrm_pkg.
`default_nettype none

module qrm_scale
    import qrm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_vld,
    input  wire s2_t  s2,
    output logic      vld_reg,
    output s4_t       s4_reg
);

    logic v3_reg;
    s3_t  s3_reg;
    s3_t  s3_next;
    s4_t  s4_next;

    // partial products; low halves are zero-extended unsigned slices
    always_comb
    begin
        s3_next      = '0;
        s3_next.func = s2.func;
        s3_next.q    = s2.q;
        s3_next.h    = s2.h;
        for (int i = 0; i < 3; i++)
        begin
            s3_next.bkh[i] = $signed(s2.bv[i]) * $signed(s2.k[KW-1:KL]);
            s3_next.bkl[i] = $signed(s2.bv[i]) * $signed({1'b0, s2.k[KL-1:0]});
            s3_next.wch[i] = $signed(s2.q[3]) * $signed(s2.c[i][CW-1:CL]);
            s3_next.wcl[i] = $signed(s2.q[3]) * $signed({1'b0, s2.c[i][CL-1:0]});
            s3_next.qdh[i] = $signed(s2.q[i]) * $signed(s2.dot[DW-1:DL]);
            s3_next.qdl[i] = $signed(s2.q[i]) * $signed({1'b0, s2.dot[DL-1:0]});
        end
    end

    // recombine; cross and dot terms carry the factor of two
    always_comb
    begin
        s4_next      = '0;
        s4_next.func = s3_reg.func;
        s4_next.q    = s3_reg.q;
        s4_next.h    = s3_reg.h;
        for (int i = 0; i < 3; i++)
        begin
            s4_next.tbk[i] = (SUMW'($signed(s3_reg.bkh[i])) <<< KL)
                           + SUMW'($signed(s3_reg.bkl[i]));
            s4_next.twc[i] = ((SUMW'($signed(s3_reg.wch[i])) <<< CL)
                           + SUMW'($signed(s3_reg.wcl[i]))) <<< 1;
            s4_next.tqd[i] = ((SUMW'($signed(s3_reg.qdh[i])) <<< DL)
                           + SUMW'($signed(s3_reg.qdl[i]))) <<< 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg  <= 1'b0;
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg  <= in_vld;
            vld_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

endmodule

`default_nettype wire

[src/qrm_out.sv]
// Stages 5 and 6 of the quaternion unit: final sum and rounding, operation
// select, then saturation into the output register. Depends on qrm_pkg.
`default_nettype none

module qrm_out
    import qrm_pkg::*;
#(
    parameter int VEC_WIDTH = VEC_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire s4_t                   s4,
    output logic                       out_vld,
    output logic signed [VEC_WIDTH-1:0] res_x,
    output logic signed [VEC_WIDTH-1:0] res_y,
    output logic signed [VEC_WIDTH-1:0] res_z,
    output logic signed [RWW-1:0]       res_w,
    output logic                       ovf
);

    localparam logic signed [SUMW-1:0] R_HALF = SUMW'(1) <<< (3 * FRAC_BITS - 1);
    localparam logic signed [SUMW-1:0] H_HALF = SUMW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SUMW-1:0] V_MAX  =
        {{(SUMW - VEC_WIDTH + 1){1'b0}}, {(VEC_WIDTH - 1){1'b1}}};
    localparam logic signed [SUMW-1:0] V_MIN  = ~V_MAX;
    localparam logic signed [SUMW-1:0] W_MAX  =
        {{(SUMW - RWW + 1){1'b0}}, {(RWW - 1){1'b1}}};
    localparam logic signed [SUMW-1:0] W_MIN  = ~W_MAX;

    logic                    v5_reg;
    logic signed [SUMW-1:0]  sel_reg  [4];
    logic signed [SUMW-1:0]  sel_next [4];
    logic signed [SUMW-1:0]  rsum     [3];
    logic signed [SUMW-1:0]  hsum     [4];

    logic                        v6_reg;
    logic signed [VEC_WIDTH-1:0] rx_reg, ry_reg, rz_reg;
    logic signed [VEC_WIDTH-1:0] rx_next, ry_next, rz_next;
    logic signed [RWW-1:0]       rw_reg, rw_next;
    logic                        ovf_reg, ovf_next;
    logic [3:0]                  hi_cl, lo_cl;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            rsum[i] = $signed(s4.tbk[i]) + $signed(s4.twc[i]) + $signed(s4.tqd[i]) + R_HALF;
        for (int i = 0; i < 4; i++)
            hsum[i] = SUMW'($signed(s4.h[i])) + H_HALF;

        for (int i = 0; i < 4; i++)
            sel_next[i] = '0;

        case (s4.func)
            FUNC_ROT, FUNC_IROT:
            begin
                for (int i = 0; i < 3; i++)
                    sel_next[i] = rsum[i] >>> (3 * FRAC_BITS);
                sel_next[3] = '0;
            end
            FUNC_HAM:
            begin
                for (int i = 0; i < 4; i++)
                    sel_next[i] = hsum[i] >>> FRAC_BITS;
            end
            FUNC_CONJ:
            begin
                for (int i = 0; i < 3; i++)
                    sel_next[i] = -(SUMW'($signed(s4.q[i])));
                sel_next[3] = SUMW'($signed(s4.q[3]));
            end
            default:
            begin
                for (int i = 0; i < 4; i++)
                    sel_next[i] = '0;
            end
        endcase
    end

    // clamp
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            hi_cl[i] = sel_reg[i] > V_MAX;
            lo_cl[i] = sel_reg[i] < V_MIN;
        end
        hi_cl[3] = sel_reg[3] > W_MAX;
        lo_cl[3] = sel_reg[3] < W_MIN;

        rx_next = hi_cl[0] ? V_MAX[VEC_WIDTH-1:0] :
                  lo_cl[0] ? V_MIN[VEC_WIDTH-1:0] : sel_reg[0][VEC_WIDTH-1:0];
        ry_next = hi_cl[1] ? V_MAX[VEC_WIDTH-1:0] :
                  lo_cl[1] ? V_MIN[VEC_WIDTH-1:0] : sel_reg[1][VEC_WIDTH-1:0];
        rz_next = hi_cl[2] ? V_MAX[VEC_WIDTH-1:0] :
                  lo_cl[2] ? V_MIN[VEC_WIDTH-1:0] : sel_reg[2][VEC_WIDTH-1:0];
        rw_next = hi_cl[3] ? W_MAX[RWW-1:0] :
                  lo_cl[3] ? W_MIN[RWW-1:0] : sel_reg[3][RWW-1:0];
        ovf_next = |(hi_cl | lo_cl);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= in_vld;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                sel_reg[i] <= sel_next[i];
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            rz_reg  <= rz_next;
            rw_reg  <= rw_next;
            ovf_reg <= ovf_next;
        end
    end

    assign out_vld = v6_reg;
    assign res_x   = rx_reg;
    assign res_y   = ry_reg;
    assign res_z   = rz_reg;
    assign res_w   = rw_reg;
    assign ovf     = ovf_reg;

endmodule

`default_nettype wire

[src/qrm_chk.sv]
// Port-level checker for the quaternion unit, bound to the top level.
// Depends on qrm_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module qrm_chk
    import qrm_pkg::*;
#(
    parameter int VEC_WIDTH = VEC_WIDTH_DEF
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_stall,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [VEC_WIDTH-1:0]   res_x,
    input wire logic [VEC_WIDTH-1:0]   res_y,
    input wire logic [VEC_WIDTH-1:0]   res_z,
    input wire logic [RWW-1:0]         res_w,
    input wire logic                   overflow
);

    // input side holds only behind a waiting result
    `QRM_ASSERT(a_stall_src, in_stall |-> (out_valid && out_stall))

    // a waiting result always freezes the input side
    `QRM_ASSERT(a_stall_prop, (out_valid && out_stall) |-> in_stall)

    // held result stays put
    `QRM_ASSERT_NEXT(a_hold, (out_valid && out_stall), (out_valid && $stable(res_x) && $stable(res_y) && $stable(res_z) && $stable(res_w) && $stable(overflow)))

    // an accepted item reaches out_valid when the output is never held meanwhile
    `QRM_ASSERT_NEXT(a_latency, ((in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall), out_valid)

endmodule

bind quaternion_rotate_multiply_unit_core qrm_chk #(
    .VEC_WIDTH (VEC_WIDTH)
) u_qrm_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z),
    .res_w     (res_w),
    .overflow  (overflow)
);

`default_nettype wire
